FILE: hw/rtl/encoder_position_tracker_defines.svh
// ----------------------------------------------------------------------------
// encoder position tracker assertion macros
// concurrent assertion helpers shared by the tracker checker
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_TRACKER_DEFINES_SVH
`define ENCODER_POSITION_TRACKER_DEFINES_SVH

// antecedent and consequent checked at the same clock edge
`define EPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked at the clock edge after the antecedent
`define EPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ept_pkg.sv
// ----------------------------------------------------------------------------
// ept_pkg
// shared types and constants of the encoder position tracker
// ----------------------------------------------------------------------------
package ept_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 21;
  localparam int unsigned MAX_ANGLE_BITS = 24;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 216;
  localparam int unsigned OUT_ERR_LSB = 184;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // register indexes, byte address is four times the index
  localparam logic [2:0] REG_POLE_PAIRS    = 3'd0;
  localparam logic [2:0] REG_ELEC_OFFSET   = 3'd1;
  localparam logic [2:0] REG_INVERT_DIR    = 3'd2;
  localparam logic [2:0] REG_POSITION_ALPHA = 3'd3;
  localparam logic [2:0] REG_VELOCITY_ALPHA = 3'd4;

  localparam logic [7:0]  POLE_PAIRS_RST     = 8'd7;
  localparam logic [20:0] ELEC_OFFSET_RST    = 21'd0;
  localparam logic        INVERT_DIR_RST     = 1'b0;
  localparam logic [15:0] POSITION_ALPHA_RST = 16'd52429;
  localparam logic [15:0] VELOCITY_ALPHA_RST = 16'd32768;

  typedef struct packed {
    logic [7:0]  pole_pairs;
    logic [20:0] elec_offset;
    logic        invert_direction;
    logic [15:0] position_alpha;
    logic [15:0] velocity_alpha;
  } cfg_t;

  typedef struct packed {
    logic        crc_good;
    logic [2:0]  sensor_status;
    logic [20:0] used_angle;
    logic [21:0] step_delta;
    logic [63:0] multiturn_position;
    logic [20:0] elec_angle_ticks;
    logic [20:0] drive_angle_ticks;
    logic [31:0] filtered_velocity;
    logic [31:0] crc_errors;
  } res_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

FILE: hw/rtl/ept_mul.sv
// ----------------------------------------------------------------------------
// ept_mul
// shared 32 x 16 unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module ept_mul (
  input  logic                          clk_i,
  input  ept_pkg::mul_req_t             req_i,
  output logic [ept_pkg::MUL_P_W-1:0]   prod_o
);
  import ept_pkg::*;

  logic [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_P_W'(req_i.a) * MUL_P_W'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/ept_core.sv
// ----------------------------------------------------------------------------
// ept_core
// sequencer and datapath: crc check, unwrap, accumulation, ewma filters and
// electrical angle, all products through the shared multiplier
// ----------------------------------------------------------------------------
module ept_core #(
  parameter int unsigned ANGLE_BITS = ept_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ept_pkg::IN_DATA_W-1:0]  in_data_i,
  input  ept_pkg::cfg_t                  cfg_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output ept_pkg::res_t                  res_o
);
  import ept_pkg::*;

  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [1:0] CrcLastByte = 2'd2;
  localparam logic [ANGLE_BITS:0] HalfTurn = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS:0] FullTurn = (ANGLE_BITS+1)'(1) << ANGLE_BITS;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_CRC    = 17'h00002,
    S_UNWRAP = 17'h00004,
    S_ACC    = 17'h00008,
    S_PDIF   = 17'h00010,
    S_ABS    = 17'h00020,
    S_MHI    = 17'h00040,
    S_MLO    = 17'h00080,
    S_SUM    = 17'h00100,
    S_SIGN   = 17'h00200,
    S_APPLY  = 17'h00400,
    S_RAW    = 17'h00800,
    S_SAT    = 17'h01000,
    S_VDIF   = 17'h02000,
    S_ELEC   = 17'h04000,
    S_ELEC2  = 17'h08000,
    S_DONE   = 17'h10000
  } state_e;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  state_e state_q, state_d;

  logic [1:0]            cnt_q;
  logic [7:0]            b0_q, b1_q, b2_q, rc_q, crc_q;
  logic                  primed_q;
  logic [ANGLE_BITS-1:0] last_good_q, cur_q, used_q, elec_q;
  logic [ANGLE_BITS:0]   delta_q;
  logic [63:0]           acc_q, pf_q, pfp_q;
  logic [31:0]           v_q, err_q, vraw_q;
  logic                  phase_q, neg_q;
  logic [63:0]           d_q, m_q, r_q, s_q, raw_q;
  logic [MUL_P_W-1:0]    ph_q;

  logic [7:0]            crc_byte;
  logic [MAX_ANGLE_BITS-1:0] frame_bits;
  logic [ANGLE_BITS-1:0] frame_angle, ang, drive;
  logic                  good;
  logic [ANGLE_BITS:0]   diff, delta_unw;
  logic [15:0]           alpha;
  mul_req_t              mul_req;
  logic [MUL_P_W-1:0]    prod;
  logic [MUL_P_W:0]      pl_rnd;
  logic [63:0]           r_sum, rn, delta64;
  logic [31:0]           vsat, off32, used32, elec32, drive32;

  ept_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // crc runs one byte per cycle
  always_comb begin
    case (cnt_q)
      2'd0:    crc_byte = b0_q;
      2'd1:    crc_byte = b1_q;
      default: crc_byte = b2_q;
    endcase
  end

  // frame angle is msb aligned, low bits dropped or zeros appended
  assign frame_bits  = {b0_q, b1_q, b2_q[7:3], 3'b000};
  assign frame_angle = frame_bits[MAX_ANGLE_BITS-1 -: ANGLE_BITS];
  assign good        = (crc_q == rc_q);
  assign ang         = good ? frame_angle : last_good_q;

  // unwrap at half a turn, exactly plus or minus half stays
  always_comb begin
    diff = {1'b0, ang} - {1'b0, cur_q};
    if (!diff[ANGLE_BITS] && (diff > HalfTurn)) begin
      delta_unw = diff - FullTurn;
    end else if (diff[ANGLE_BITS] && ((~diff + 1'b1) > HalfTurn)) begin
      delta_unw = diff + FullTurn;
    end else begin
      delta_unw = diff;
    end
  end

  assign alpha = phase_q ? cfg_i.velocity_alpha : cfg_i.position_alpha;

  always_comb begin
    mul_req.a = '0;
    mul_req.b = '0;
    case (state_q)
      S_MHI: begin
        mul_req.a = m_q[63:32];
        mul_req.b = alpha;
      end
      S_MLO: begin
        mul_req.a = m_q[31:0];
        mul_req.b = alpha;
      end
      S_ELEC: begin
        mul_req.a = MUL_A_W'(acc_q[ANGLE_BITS-1:0]);
        mul_req.b = MUL_B_W'(cfg_i.pole_pairs);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // round half away from zero on the magnitude
  assign pl_rnd = {1'b0, prod} + (MUL_P_W+1)'(32768);
  assign r_sum  = {ph_q, 16'h0000} + {31'h0, pl_rnd[MUL_P_W:16]};

  assign rn = cfg_i.invert_direction ? (64'd0 - raw_q) : raw_q;

  always_comb begin
    if (rn[63] && !(&rn[62:31])) begin
      vsat = 32'h8000_0000;
    end else if (!rn[63] && (|rn[62:31])) begin
      vsat = 32'h7FFF_FFFF;
    end else begin
      vsat = rn[31:0];
    end
  end

  assign off32 = 32'(cfg_i.elec_offset);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_CRC;
      S_CRC:    if (cnt_q == CrcLastByte) state_d = S_UNWRAP;
      S_UNWRAP: state_d = primed_q ? S_ACC : S_ELEC;
      S_ACC:    state_d = S_PDIF;
      S_PDIF:   state_d = S_ABS;
      S_ABS:    state_d = S_MHI;
      S_MHI:    state_d = S_MLO;
      S_MLO:    state_d = S_SUM;
      S_SUM:    state_d = S_SIGN;
      S_SIGN:   state_d = S_APPLY;
      S_APPLY:  state_d = phase_q ? S_ELEC : S_RAW;
      S_RAW:    state_d = S_SAT;
      S_SAT:    state_d = S_VDIF;
      S_VDIF:   state_d = S_ABS;
      S_ELEC:   state_d = S_ELEC2;
      S_ELEC2:  state_d = S_DONE;
      S_DONE:   if (res_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control and tracked state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      primed_q    <= 1'b0;
      last_good_q <= '0;
      cur_q       <= '0;
      acc_q       <= '0;
      pf_q        <= '0;
      pfp_q       <= '0;
      v_q         <= '0;
      err_q       <= '0;
      phase_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
        end
        S_CRC: begin
          cnt_q <= cnt_q + 2'd1;
        end
        S_UNWRAP: begin
          if (!primed_q) begin
            primed_q    <= 1'b1;
            last_good_q <= frame_angle;
            cur_q       <= frame_angle;
            acc_q       <= 64'(frame_angle);
            pf_q        <= 64'(frame_angle) << 8;
            pfp_q       <= 64'(frame_angle) << 8;
          end else begin
            if (!good) begin
              if (!(&err_q)) err_q <= err_q + 32'd1;
            end else begin
              last_good_q <= frame_angle;
            end
            cur_q <= ang;
          end
        end
        S_ACC: begin
          acc_q <= acc_q + 64'(signed'(delta_q));
        end
        S_PDIF: begin
          phase_q <= 1'b0;
        end
        S_APPLY: begin
          if (phase_q) begin
            v_q <= v_q + s_q[31:0];
          end else begin
            pf_q <= pf_q + s_q;
          end
        end
        S_RAW: begin
          pfp_q <= pf_q;
        end
        S_VDIF: begin
          phase_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          b0_q  <= in_data_i[7:0];
          b1_q  <= in_data_i[15:8];
          b2_q  <= in_data_i[23:16];
          rc_q  <= in_data_i[31:24];
          crc_q <= '0;
        end
      end
      S_CRC: begin
        crc_q <= crc8_byte(crc_q, crc_byte);
      end
      S_UNWRAP: begin
        if (!primed_q) begin
          used_q  <= frame_angle;
          delta_q <= '0;
        end else begin
          used_q  <= ang;
          delta_q <= delta_unw;
        end
      end
      S_PDIF: begin
        d_q <= {acc_q[55:0], 8'h00} - pf_q;
      end
      S_ABS: begin
        neg_q <= d_q[63];
        m_q   <= d_q[63] ? (64'd0 - d_q) : d_q;
      end
      S_MLO: begin
        ph_q <= prod;
      end
      S_SUM: begin
        r_q <= r_sum;
      end
      S_SIGN: begin
        s_q <= neg_q ? (64'd0 - r_q) : r_q;
      end
      S_RAW: begin
        raw_q <= pf_q - pfp_q;
      end
      S_SAT: begin
        vraw_q <= vsat;
      end
      S_VDIF: begin
        d_q <= 64'(signed'(vraw_q)) - 64'(signed'(v_q));
      end
      S_ELEC2: begin
        elec_q <= prod[ANGLE_BITS-1:0] - off32[ANGLE_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  assign drive   = cfg_i.invert_direction ? (ANGLE_BITS'(0) - elec_q) : elec_q;
  assign used32  = 32'(used_q);
  assign elec32  = 32'(elec_q);
  assign drive32 = 32'(drive);
  assign delta64 = 64'(signed'(delta_q));

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.crc_good           = good;
    res_o.sensor_status      = b2_q[2:0];
    res_o.used_angle         = used32[20:0];
    res_o.step_delta         = delta64[21:0];
    res_o.multiturn_position = acc_q;
    res_o.elec_angle_ticks   = elec32[20:0];
    res_o.drive_angle_ticks  = drive32[20:0];
    res_o.filtered_velocity  = v_q;
    res_o.crc_errors         = err_q;
  end

endmodule

FILE: hw/rtl/encoder_position_tracker.sv
// ----------------------------------------------------------------------------
// encoder_position_tracker
// multi-turn tracker for an absolute angle sensor with crc-8 framed samples
//
// s_axis carries one sensor frame per transfer, m_axis one result per frame.
// the user must write registers over the apb port only while no frame is
// in flight; the block itself does not enforce this. a frame is taken only
// while the sequencer is idle, so a new frame waits until the previous one
// is finished. the priming frame skips the ewma updates. the sequencer runs
// the crc one byte per cycle and steps two ewma updates and the pole-pair
// product through one shared 32 x 16 multiplier.
// a finished result sits in the output register; the next frame is accepted
// meanwhile, and if m_axis is stalled the sequencer holds its result until
// the register frees up.
// reset restores the register defaults and clears all tracked state; the
// first frame afterwards only primes the angle, position and filters.
// ----------------------------------------------------------------------------
module encoder_position_tracker #(
  parameter int unsigned ANGLE_BITS = ept_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // angle_high, angle_mid, angle_low_status, frame_crc
  input  logic [ept_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // sensor_status, used_angle, step_delta, multiturn_position,
  // elec_angle_ticks, drive_angle_ticks, filtered_velocity, crc_errors
  output logic [ept_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // crc_good
  output logic [0:0]                       m_axis_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ept_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ept_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ept_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import ept_pkg::*;

  cfg_t        cfg_q;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic        res_valid, res_ready;
  res_t        res, out_q;
  logic        out_valid_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pole_pairs       <= POLE_PAIRS_RST;
      cfg_q.elec_offset      <= ELEC_OFFSET_RST;
      cfg_q.invert_direction <= INVERT_DIR_RST;
      cfg_q.position_alpha   <= POSITION_ALPHA_RST;
      cfg_q.velocity_alpha   <= VELOCITY_ALPHA_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_POLE_PAIRS:     cfg_q.pole_pairs       <= pwdata[7:0];
        REG_ELEC_OFFSET:    cfg_q.elec_offset      <= pwdata[20:0];
        REG_INVERT_DIR:     cfg_q.invert_direction <= pwdata[0];
        REG_POSITION_ALPHA: cfg_q.position_alpha   <= pwdata[15:0];
        REG_VELOCITY_ALPHA: cfg_q.velocity_alpha   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POLE_PAIRS:     prdata = APB_DATA_W'(cfg_q.pole_pairs);
      REG_ELEC_OFFSET:    prdata = APB_DATA_W'(cfg_q.elec_offset);
      REG_INVERT_DIR:     prdata = APB_DATA_W'(cfg_q.invert_direction);
      REG_POSITION_ALPHA: prdata = APB_DATA_W'(cfg_q.position_alpha);
      REG_VELOCITY_ALPHA: prdata = APB_DATA_W'(cfg_q.velocity_alpha);
      default:            prdata = '0;
    endcase
  end

  ept_core #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register frees up in the cycle its transfer completes
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.crc_good;
  assign m_axis_tdata  = {out_q.crc_errors, out_q.filtered_velocity, out_q.drive_angle_ticks,
                          out_q.elec_angle_ticks, out_q.multiturn_position, out_q.step_delta,
                          out_q.used_angle, out_q.sensor_status};

endmodule

FILE: hw/rtl/ept_checker.sv
// ----------------------------------------------------------------------------
// ept_checker
// port-level checks of the encoder position tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "encoder_position_tracker_defines.svh"

module ept_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ept_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import ept_pkg::*;

  logic        err_seen_q;
  logic [31:0] err_last_q;
  logic        out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // error count of the last result transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
      err_last_q <= '0;
    end else if (out_xfer) begin
      err_seen_q <= 1'b1;
      err_last_q <= m_axis_tdata[OUT_DATA_W-1:OUT_ERR_LSB];
    end
  end

  `EPT_ASSERT_NEXT(a_busy_after_frame, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "frame taken while the previous one is still in work")
  `EPT_ASSERT_SAME(a_err_monotonic, clk_i, rst_ni, out_xfer && err_seen_q, m_axis_tdata[OUT_DATA_W-1:OUT_ERR_LSB] >= err_last_q, "crc error count went down")
  `EPT_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `EPT_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind encoder_position_tracker ept_checker u_ept_checker (.*);

FILE: sim/encoder_position_tracker_tb.sv
// ----------------------------------------------------------------------------
// encoder_position_tracker_tb
// self-checking bench for the encoder position tracker: sensor frames go in
// on s_axis with random gaps, results leave on m_axis under random stalls and
// are compared field by field against a cycle-free tracker kept in the bench.
// registers are set over apb between phases, read back, and swept through
// their extremes, including zero pole pairs
// ----------------------------------------------------------------------------
module encoder_position_tracker_tb;
  import ept_pkg::*;

  localparam logic [63:0] HALF = 64'h0010_0000;
  localparam logic [63:0] TURN = 64'h0020_0000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned FRAMES_PER_PHASE = 150;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // angle_high, angle_mid, angle_low_status, frame_crc
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // sensor_status, used_angle, step_delta, multiturn_position,
  // elec_angle_ticks, drive_angle_ticks, filtered_velocity, crc_errors
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // crc_good
  logic [0:0]            m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  encoder_position_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bench copy of the configuration and the tracking state
  cfg_t        cfg;
  logic        seen_first = 1'b0;
  logic [20:0] good_angle = '0;
  logic [20:0] prev_angle = '0;
  logic [63:0] turns_pos = '0;
  logic [63:0] pos_smooth = '0;
  logic [63:0] pos_smooth_last = '0;
  logic [31:0] vel_smooth = '0;
  logic [31:0] crc_fail_total = '0;

  logic [31:0] frame_q[$];
  res_t        sample_q[$];
  logic        in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;
  int unsigned frames_queued = 0;
  int unsigned frames_taken = 0;
  int unsigned results_seen = 0;
  int unsigned bad_crc_seen = 0;
  int unsigned settings_used = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  logic [20:0] trail = '0;
  logic [20:0] drift = '0;

  function automatic logic [7:0] crc8(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
    return c;
  endfunction

  // round(a * d / 2^16), half away from zero, d two's complement
  function automatic logic [63:0] weigh_q16(logic [63:0] d, logic [15:0] a);
    logic [63:0] m, ph, pl, r;
    m = d[63] ? 64'd0 - d : d;
    ph = {32'd0, m[63:32]} * {48'd0, a};
    pl = {32'd0, m[31:0]} * {48'd0, a};
    r = (ph << 16) + ((pl + 64'd32768) >> 16);
    return d[63] ? 64'd0 - r : r;
  endfunction

  function automatic res_t track_frame(logic [31:0] frame);
    logic [7:0]  hi, mid, lo, rx_crc, crc;
    logic [63:0] ang, delta, fnew, raw, vel_x, prod;
    logic [20:0] elec;
    res_t        r;
    hi = frame[7:0];
    mid = frame[15:8];
    lo = frame[23:16];
    rx_crc = frame[31:24];
    crc = crc8(crc8(crc8(8'h00, hi), mid), lo);
    ang = {43'd0, hi, mid, lo[7:3]};
    delta = '0;
    if (!seen_first) begin
      // first frame primes everything, crc ignored
      seen_first = 1'b1;
      good_angle = ang[20:0];
      prev_angle = ang[20:0];
      turns_pos = ang;
      pos_smooth = ang << 8;
      pos_smooth_last = pos_smooth;
    end else begin
      if (crc != rx_crc) begin
        if (crc_fail_total != '1) crc_fail_total++;
        ang = {43'd0, good_angle};
      end else begin
        good_angle = ang[20:0];
      end
      delta = ang - {43'd0, prev_angle};
      prev_angle = ang[20:0];
      // unwrap; exactly half a turn either way is left alone
      if (!delta[63]) begin
        if (delta > HALF) delta -= TURN;
      end else if ((64'd0 - delta) > HALF) begin
        delta += TURN;
      end
      turns_pos += delta;
      fnew = pos_smooth + weigh_q16((turns_pos << 8) - pos_smooth, cfg.position_alpha);
      raw = fnew - pos_smooth_last;
      pos_smooth = fnew;
      pos_smooth_last = fnew;
      if (cfg.invert_direction) raw = 64'd0 - raw;
      if (raw[63]) begin
        if ((64'd0 - raw) > 64'h8000_0000) raw = 64'hFFFF_FFFF_8000_0000;
      end else if (raw > 64'h7FFF_FFFF) begin
        raw = 64'h7FFF_FFFF;
      end
      vel_x = {{32{vel_smooth[31]}}, vel_smooth};
      vel_x = vel_x + weigh_q16(raw - vel_x, cfg.velocity_alpha);
      vel_smooth = vel_x[31:0];
    end
    prod = {43'd0, turns_pos[20:0]} * {56'd0, cfg.pole_pairs};
    elec = prod[20:0] - cfg.elec_offset;
    r.crc_good = (crc == rx_crc);
    r.sensor_status = lo[2:0];
    r.used_angle = ang[20:0];
    r.step_delta = delta[21:0];
    r.multiturn_position = turns_pos;
    r.elec_angle_ticks = elec;
    r.drive_angle_ticks = cfg.invert_direction ? 21'd0 - elec : elec;
    r.filtered_velocity = vel_smooth;
    r.crc_errors = crc_fail_total;
    return r;
  endfunction

  function automatic logic [31:0] make_frame(logic [20:0] a, logic [2:0] st, logic corrupt);
    logic [7:0] c;
    c = crc8(crc8(crc8(8'h00, a[20:13]), a[12:5]), {a[4:0], st});
    if (corrupt) c ^= 8'($urandom_range(1, 255));
    return {c, a[4:0], st, a[12:5], a[20:13]};
  endfunction

  // mostly a plausible shaft trajectory, with jumps, half-turn steps,
  // corrupted frames and raw noise mixed in
  function automatic logic [31:0] random_frame();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick >= 90) return $urandom();
    if (pick < 62) begin
      trail = trail + drift + 21'($urandom_range(0, 64)) - 21'd32;
    end else if (pick < 72) begin
      trail = 21'($urandom());
    end else if (pick < 80) begin
      trail = trail + 21'(HALF) + 21'($urandom_range(0, 2)) - 21'd1;
    end
    return make_frame(trail, 3'($urandom_range(0, 7)), pick >= 80);
  endfunction

  // gap or stall length: mostly short, a few long, sometimes a calm stretch
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned pick;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 24);
    return $urandom_range(25, 80);
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_POLE_PAIRS:     return {24'd0, cfg.pole_pairs};
      REG_ELEC_OFFSET:    return {11'd0, cfg.elec_offset};
      REG_INVERT_DIR:     return {31'd0, cfg.invert_direction};
      REG_POSITION_ALPHA: return {16'd0, cfg.position_alpha};
      REG_VELOCITY_ALPHA: return {16'd0, cfg.velocity_alpha};
      default:            return '0;
    endcase
  endfunction

  task automatic reg_check(logic [2:0] idx);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== reg_value(idx)) begin
      $error("register %0d: expected %0h, got %0h", idx, reg_value(idx), prdata);
      failures++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_POLE_PAIRS:     cfg.pole_pairs = value[7:0];
      REG_ELEC_OFFSET:    cfg.elec_offset = value[20:0];
      REG_INVERT_DIR:     cfg.invert_direction = value[0];
      REG_POSITION_ALPHA: cfg.position_alpha = value[15:0];
      REG_VELOCITY_ALPHA: cfg.velocity_alpha = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_check(idx);
  endtask

  task automatic apply_setting(logic [31:0] pp, logic [31:0] off, logic [31:0] inv,
                               logic [31:0] pa, logic [31:0] va);
    reg_write(REG_POLE_PAIRS, pp);
    reg_write(REG_ELEC_OFFSET, off);
    reg_write(REG_INVERT_DIR, inv);
    reg_write(REG_POSITION_ALPHA, pa);
    reg_write(REG_VELOCITY_ALPHA, va);
    settings_used++;
  endtask

  task automatic queue_frame(logic [31:0] frame);
    frame_q.push_back(frame);
    frames_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (frames_taken != frames_queued || sample_q.size() != 0);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // frame driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (frame_q.size() != 0) begin
        s_axis_tdata <= frame_q.pop_front();
        s_axis_tvalid <= 1'b1;
        gap_left = idle_len(tx_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left = idle_len(rx_calm);
      end
    end
  end

  // monitor: results checked first, then the accepted frame is tracked
  always @(posedge clk_i) begin
    res_t got, want;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.crc_good = m_axis_tuser[0];
        got.sensor_status = m_axis_tdata[2:0];
        got.used_angle = m_axis_tdata[23:3];
        got.step_delta = m_axis_tdata[45:24];
        got.multiturn_position = m_axis_tdata[109:46];
        got.elec_angle_ticks = m_axis_tdata[130:110];
        got.drive_angle_ticks = m_axis_tdata[151:131];
        got.filtered_velocity = m_axis_tdata[183:152];
        got.crc_errors = m_axis_tdata[OUT_ERR_LSB +: 32];
        results_seen++;
        if (sample_q.size() == 0) begin
          $error("result transfer with no frame outstanding");
          failures++;
        end else begin
          want = sample_q.pop_front();
          if (!want.crc_good) bad_crc_seen++;
          check_field("crc_good", 64'(want.crc_good), 64'(got.crc_good));
          check_field("sensor_status", 64'(want.sensor_status), 64'(got.sensor_status));
          check_field("used_angle", 64'(want.used_angle), 64'(got.used_angle));
          check_field("step_delta", 64'(want.step_delta), 64'(got.step_delta));
          check_field("multiturn_position", want.multiturn_position,
                      got.multiturn_position);
          check_field("elec_angle_ticks", 64'(want.elec_angle_ticks),
                      64'(got.elec_angle_ticks));
          check_field("drive_angle_ticks", 64'(want.drive_angle_ticks),
                      64'(got.drive_angle_ticks));
          check_field("filtered_velocity", 64'(want.filtered_velocity),
                      64'(got.filtered_velocity));
          check_field("crc_errors", 64'(want.crc_errors), 64'(got.crc_errors));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sample_q.push_back(track_frame(s_axis_tdata));
        frames_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("encoder_position_tracker_tb failed");
      $finish;
    end
  end

  initial begin
    cfg = '{POLE_PAIRS_RST, ELEC_OFFSET_RST, INVERT_DIR_RST, POSITION_ALPHA_RST,
            VELOCITY_ALPHA_RST};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults after reset
    reg_check(REG_POLE_PAIRS);
    reg_check(REG_ELEC_OFFSET);
    reg_check(REG_INVERT_DIR);
    reg_check(REG_POSITION_ALPHA);
    reg_check(REG_VELOCITY_ALPHA);

    // priming frame with a corrupt crc still takes its angle
    queue_frame(make_frame(21'h1F_FFFF, 3'd7, 1'b1));
    queue_frame(make_frame(21'h00_0000, 3'd0, 1'b0));   // wraps forward by one
    queue_frame(make_frame(21'h10_0000, 3'd5, 1'b0));   // exactly plus half a turn
    queue_frame(make_frame(21'h00_0000, 3'd2, 1'b0));   // exactly minus half a turn
    queue_frame(make_frame(21'h10_0001, 3'd1, 1'b0));   // just past half, goes negative
    queue_frame(make_frame(21'h00_0000, 3'd3, 1'b0));
    queue_frame(make_frame(21'($urandom()), 3'd4, 1'b1)); // bad crc reuses last angle
    queue_frame(make_frame(21'($urandom()), 3'd6, 1'b1));
    queue_frame(32'h0000_0000);
    queue_frame(32'hFFFF_FFFF);
    queue_frame(make_frame(21'h1F_FFFF, 3'd7, 1'b0));
    queue_frame(make_frame(21'h0F_FFFF, 3'd0, 1'b0));
    queue_frame(make_frame(21'h1F_FFFF, 3'd5, 1'b0));
    queue_frame(make_frame(21'h1F_FF00, 3'd2, 1'b0));
    queue_frame(make_frame(21'h00_0100, 3'd6, 1'b0));
    queue_frame(make_frame(21'h00_0180, 3'd1, 1'b0));
    trail = 21'h00_0180;
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_setting(32'd255, 32'h001F_FFFF, 32'd1, 32'd65535, 32'd65535);
        1: apply_setting(32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
        2: apply_setting(32'd0, $urandom(), $urandom(), $urandom(), $urandom());
        3: apply_setting(32'(POLE_PAIRS_RST), 32'd0, 32'd0, 32'(POSITION_ALPHA_RST),
                         32'(VELOCITY_ALPHA_RST));
        default: apply_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      endcase
      drift = 21'($urandom_range(0, 40000)) - 21'd20000;
      repeat (FRAMES_PER_PHASE) queue_frame(random_frame());
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (sample_q.size() != 0) begin
      $error("%0d results never arrived", sample_q.size());
      failures++;
    end
    $display("%0d frames tracked, %0d of them with a failed crc, %0d results checked",
             frames_taken, bad_crc_seen, results_seen);
    $display("%0d register settings applied and read back", settings_used);
    if (failures == 0) begin
      $display("encoder_position_tracker_tb passed");
    end else begin
      $display("encoder_position_tracker_tb failed");
    end
    $finish;
  end

endmodule
